// File: design/hms_pkg.sv
// Shared types and constants for the height map sampler.
`default_nettype none

package hms_pkg;

    localparam int STORE_DEPTH         = 65536;
    localparam int STORE_AW            = 16;
    localparam int DEF_MAX_MAP_SIDE    = 256;
    localparam int DEF_MAX_HALF_WINDOW = 16;
    localparam int HEIGHT_MAX          = 8388607;
    localparam int HEIGHT_MIN          = -8388608;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 16;

    localparam logic [1:0] FN_WRITE = 2'd0;
    localparam logic [1:0] FN_BILIN = 2'd1;
    localparam logic [1:0] FN_BOX   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_Y    = 3'd3;

    localparam logic [8:0]  RST_MAP_SIDE = 9'd256;
    localparam logic [15:0] RST_RATIO    = 16'd4096;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BL_RD,
        ST_BL_MUL,
        ST_BOX_MUL,
        ST_BOX_SCAN,
        ST_BOX_DRAIN,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [15:0]        map_addr;
        logic [7:0]         height_value;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic [18:0]        half_extent;
    } req_t;

    typedef struct packed {
        logic signed [23:0] height;
        logic               empty_window;
    } rsp_t;

endpackage

`default_nettype wire

// File: design/heightmap_sampler.sv
// Height map sampler: store, bilinear query and box average on one shared multiplier.
// A write is stored from the idle state; a bilinear query reads its four corners on the
// single read port, then runs 8 steps of the shared multiplier, then outputs.
// A box query runs setup steps on the shared multiplier, scans one sample per cycle in the
// window, then runs a restoring divider of one quotient bit a cycle; one item is in work at a time.
// Reset clears control state and loads the register defaults; the store is not cleared.
`default_nettype none

module heightmap_sampler #(
    parameter int MAX_MAP_SIDE    = hms_pkg::DEF_MAX_MAP_SIDE,
    parameter int MAX_HALF_WINDOW = hms_pkg::DEF_MAX_HALF_WINDOW
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_stall,
    input  wire hms_pkg::req_t                    req,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_stall,
    output hms_pkg::rsp_t                         rsp,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [hms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hms_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int XW     = $clog2(MAX_MAP_SIDE);
    localparam int SW     = $clog2(MAX_MAP_SIDE + 1);
    localparam int AMW    = XW + SW + 1;
    localparam int HW     = $clog2(MAX_HALF_WINDOW + 1);
    localparam int SIDE_W = $clog2(2 * MAX_HALF_WINDOW + 3);
    localparam int CNT_W  = 2 * SIDE_W;
    localparam int SUM_W  = CNT_W + 8;
    localparam int DVW    = SUM_W + 8;
    localparam int DCW    = $clog2(DVW + 1);
    localparam int MAX_CNT = (2 * MAX_HALF_WINDOW + 2) * (2 * MAX_HALF_WINDOW + 2);
    localparam int CW     = 18;
    localparam int PW     = 37;
    localparam int BW     = 40;
    localparam logic signed [BW-1:0] RND = BW'((1 << 20) - 1);

    // ------------------------------------------------------------------
    // State
    hms_pkg::state_t state_reg, state_next;
    logic [2:0]     rd_idx_reg, rd_idx_next;
    logic [2:0]     step_reg, step_next;
    logic [DCW-1:0] div_cnt_reg, div_cnt_next;
    logic           pend_reg, pend_next;
    logic           rsp_valid_reg, rsp_valid_next;
    hms_pkg::rsp_t  rsp_reg, rsp_next;

    logic [8:0]  map_width_reg, map_height_reg;
    logic [15:0] ratio_x_reg, ratio_y_reg;

    logic signed [19:0]   px_reg, px_next, py_reg, py_next;
    logic [18:0]          ext_reg, ext_next;
    logic [XW-1:0]        x1_reg, x1_next, x2_reg, x2_next;
    logic [XW-1:0]        y1_reg, y1_next, y2_reg, y2_next;
    logic [7:0]           samp_reg [4];
    logic signed [53:0]   prod_reg, prod_next;
    logic signed [31:0]   r1_reg, r1_next, r2_reg, r2_next;
    logic signed [55:0]   acc_reg, acc_next;
    logic signed [PW-1:0] ppx_reg, ppx_next, ppy_reg, ppy_next;
    logic [HW-1:0]        sx_reg, sx_next, sy_reg, sy_next;
    logic signed [CW-1:0] xl_reg, xl_next, xh_reg, xh_next;
    logic signed [CW-1:0] yl_reg, yl_next, yh_reg, yh_next;
    logic signed [CW-1:0] xc_reg, xc_next, yc_reg, yc_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [DVW-1:0]       quo_reg, quo_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    hms_pkg::rsp_t        res_reg, res_next;

    logic [7:0]                  mem [hms_pkg::STORE_DEPTH];
    logic [7:0]                  rdata_reg;
    logic [hms_pkg::STORE_AW-1:0] rd_addr;
    logic                        wr_en;

    logic [SW-1:0]        w_eff, h_eff;
    logic signed [21:0]   mul_a;
    logic signed [31:0]   mul_b;
    logic signed [21:0]   wa, wb, wy1, wy2;
    logic                 slot_free;
    logic [SUM_W-1:0]     sum_add;
    logic [CNT_W:0]       rem_sh;
    logic signed [CW-1:0] bx_lo, bx_hi, by_lo, by_hi;
    logic signed [CW-1:0] q_x1t, q_y1t;
    logic signed [55:0]   acc_sh;

    // ------------------------------------------------------------------
    function automatic logic [SW-1:0] eff_side(input logic [8:0] r);
        logic [SW+9:0] rv;
        rv = (SW+10)'(r);
        if (r == 9'd0)
            return SW'(1);
        else if (rv > (SW+10)'(MAX_MAP_SIDE))
            return SW'(MAX_MAP_SIDE);
        else
            return SW'(r);
    endfunction

    function automatic logic [XW-1:0] clamp_c(input logic signed [CW-1:0] v,
                                              input logic [SW-1:0] side);
        logic signed [CW-1:0] sd;
        sd = $signed(CW'(side));
        if (v < 0)
            return '0;
        else if (v >= sd)
            return XW'(side - 1'b1);
        else
            return XW'(v);
    endfunction

    function automatic logic [hms_pkg::STORE_AW-1:0] addr_of(input logic [XW-1:0] cx,
                                                           input logic [XW-1:0] cy,
                                                           input logic [SW-1:0] w);
        logic [AMW-1:0] lin;
        lin = AMW'(cx) + AMW'(cy) * AMW'(w);
        return hms_pkg::STORE_AW'(lin);
    endfunction

    // truncate Q.8 toward zero to an integer index
    function automatic logic signed [CW-1:0] trunc8(input logic signed [19:0] p);
        logic signed [20:0] v;
        v = 21'(p) + (p[19] ? 21'sd255 : 21'sd0);
        return CW'(v >>> 8);
    endfunction

    function automatic logic signed [CW-1:0] win_lo(input logic signed [PW-1:0] p,
                                                   input logic [HW-1:0] s);
        logic signed [BW-1:0] v;
        v = BW'(p) - $signed(BW'(s) << 20);
        if (v < 0)
            v = v + RND;
        return CW'(v >>> 20);
    endfunction

    function automatic logic signed [CW-1:0] win_hi(input logic signed [PW-1:0] p,
                                                   input logic [HW-1:0] s);
        logic signed [BW-1:0] v;
        v = BW'(p) + $signed(BW'(s) << 20) + RND;
        return CW'((v >>> 20) - BW'(1));
    endfunction

    function automatic logic [HW-1:0] sat_half(input logic signed [53:0] p);
        logic [33:0] s;
        s = 34'(p >>> 20);
        if (s > 34'(MAX_HALF_WINDOW))
            return HW'(MAX_HALF_WINDOW);
        else
            return HW'(s);
    endfunction

    // ------------------------------------------------------------------
    assign w_eff     = eff_side(map_width_reg);
    assign h_eff     = eff_side(map_height_reg);
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != hms_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;
    assign wr_en     = req_valid && (state_reg == hms_pkg::ST_IDLE)
                       && (req.func == hms_pkg::FN_WRITE);

    assign wa  = $signed(22'({x2_reg, 8'h00})) - 22'(px_reg);
    assign wb  = 22'(px_reg) - $signed(22'({x1_reg, 8'h00}));
    assign wy1 = $signed(22'({y2_reg, 8'h00})) - 22'(py_reg);
    assign wy2 = 22'(py_reg) - $signed(22'({y1_reg, 8'h00}));

    assign q_x1t = trunc8(req.pos_x);
    assign q_y1t = trunc8(req.pos_y);

    assign bx_lo = win_lo(ppx_reg, sx_reg);
    assign bx_hi = win_hi(ppx_reg, sx_reg);
    assign by_lo = win_lo(ppy_reg, sy_reg);
    assign by_hi = win_hi(ppy_reg, sy_reg);

    assign sum_add = sum_reg + (pend_reg ? SUM_W'(rdata_reg) : SUM_W'(0));
    assign rem_sh  = {rem_reg, quo_reg[DVW-1]};
    assign acc_sh  = acc_reg >>> 8;

    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        rd_idx_next    = rd_idx_reg;
        step_next      = step_reg;
        div_cnt_next   = div_cnt_reg;
        pend_next      = 1'b0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        px_next  = px_reg;   py_next  = py_reg;   ext_next = ext_reg;
        x1_next  = x1_reg;   x2_next  = x2_reg;
        y1_next  = y1_reg;   y2_next  = y2_reg;
        r1_next  = r1_reg;   r2_next  = r2_reg;   acc_next = acc_reg;
        ppx_next = ppx_reg;  ppy_next = ppy_reg;
        sx_next  = sx_reg;   sy_next  = sy_reg;
        xl_next  = xl_reg;   xh_next  = xh_reg;
        yl_next  = yl_reg;   yh_next  = yh_reg;
        xc_next  = xc_reg;   yc_next  = yc_reg;
        cnt_next = cnt_reg;  sum_next = sum_add;
        quo_next = quo_reg;  rem_next = rem_reg;
        res_next = res_reg;
        mul_a    = '0;
        mul_b    = '0;
        rd_addr  = req.map_addr;

        unique case (state_reg)
            hms_pkg::ST_IDLE:
            begin
                px_next  = req.pos_x;
                py_next  = req.pos_y;
                ext_next = req.half_extent;
                x1_next  = clamp_c(q_x1t, w_eff);
                x2_next  = clamp_c(q_x1t + CW'(1), w_eff);
                y1_next  = clamp_c(q_y1t, h_eff);
                y2_next  = clamp_c(q_y1t + CW'(1), h_eff);
                rd_idx_next = '0;
                step_next   = '0;
                if (req_valid && req.func == hms_pkg::FN_BILIN)
                    state_next = hms_pkg::ST_BL_RD;
                else if (req_valid && req.func == hms_pkg::FN_BOX)
                    state_next = hms_pkg::ST_BOX_MUL;
            end

            hms_pkg::ST_BL_RD:
            begin
                // corner order: (x1,y1) (x2,y1) (x1,y2) (x2,y2)
                case (rd_idx_reg[1:0])
                    2'd0:    rd_addr = addr_of(x1_reg, y1_reg, w_eff);
                    2'd1:    rd_addr = addr_of(x2_reg, y1_reg, w_eff);
                    2'd2:    rd_addr = addr_of(x1_reg, y2_reg, w_eff);
                    default: rd_addr = addr_of(x2_reg, y2_reg, w_eff);
                endcase
                rd_idx_next = rd_idx_reg + 3'd1;
                if (rd_idx_reg == 3'd4)
                    state_next = hms_pkg::ST_BL_MUL;
            end

            hms_pkg::ST_BL_MUL:
            begin
                case (step_reg)
                    3'd0:    begin mul_a = wa;  mul_b = 32'(samp_reg[0]); end
                    3'd1:    begin mul_a = wb;  mul_b = 32'(samp_reg[1]); end
                    3'd2:    begin mul_a = wa;  mul_b = 32'(samp_reg[2]); end
                    3'd3:    begin mul_a = wb;  mul_b = 32'(samp_reg[3]); end
                    3'd4:    begin mul_a = wy1; mul_b = r1_reg; end
                    3'd5:    begin mul_a = wy2; mul_b = r2_reg; end
                    default: begin mul_a = '0;  mul_b = '0; end
                endcase
                case (step_reg)
                    3'd1:    r1_next  = 32'(prod_reg);
                    3'd2:    r1_next  = r1_reg + 32'(prod_reg);
                    3'd3:    r2_next  = 32'(prod_reg);
                    3'd4:    r2_next  = r2_reg + 32'(prod_reg);
                    3'd5:    acc_next = 56'(prod_reg);
                    3'd6:    acc_next = acc_reg + 56'(prod_reg);
                    default: ;
                endcase
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    res_next.empty_window = 1'b0;
                    if (acc_sh > 56'(hms_pkg::HEIGHT_MAX))
                        res_next.height = 24'(hms_pkg::HEIGHT_MAX);
                    else if (acc_sh < 56'(hms_pkg::HEIGHT_MIN))
                        res_next.height = 24'(hms_pkg::HEIGHT_MIN);
                    else
                        res_next.height = 24'(acc_sh);
                    state_next = hms_pkg::ST_DONE;
                end
            end

            hms_pkg::ST_BOX_MUL:
            begin
                case (step_reg)
                    3'd0:    begin mul_a = 22'(px_reg);  mul_b = 32'(ratio_x_reg); end
                    3'd1:    begin mul_a = 22'(py_reg);  mul_b = 32'(ratio_y_reg); end
                    3'd2:    begin mul_a = 22'(ext_reg); mul_b = 32'(ratio_x_reg); end
                    3'd3:    begin mul_a = 22'(ext_reg); mul_b = 32'(ratio_y_reg); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
                case (step_reg)
                    3'd1:    ppx_next = PW'(prod_reg);
                    3'd2:    ppy_next = PW'(prod_reg);
                    3'd3:    sx_next  = sat_half(prod_reg);
                    3'd4:    sy_next  = sat_half(prod_reg);
                    default: ;
                endcase
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd5)
                begin
                    xl_next  = bx_lo;  xh_next = bx_hi;
                    yl_next  = by_lo;  yh_next = by_hi;
                    xc_next  = bx_lo;  yc_next = by_lo;
                    cnt_next = '0;
                    sum_next = '0;
                    if (bx_lo > bx_hi || by_lo > by_hi)
                    begin
                        res_next.height       = '0;
                        res_next.empty_window = 1'b1;
                        state_next = hms_pkg::ST_DONE;
                    end
                    else
                        state_next = hms_pkg::ST_BOX_SCAN;
                end
            end

            hms_pkg::ST_BOX_SCAN:
            begin
                rd_addr   = addr_of(clamp_c(xc_reg, w_eff), clamp_c(yc_reg, h_eff), w_eff);
                pend_next = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (xc_reg == xh_reg)
                begin
                    xc_next = xl_reg;
                    if (yc_reg == yh_reg)
                        state_next = hms_pkg::ST_BOX_DRAIN;
                    else
                        yc_next = yc_reg + CW'(1);
                end
                else
                    xc_next = xc_reg + CW'(1);
            end

            hms_pkg::ST_BOX_DRAIN:
            begin
                // last sample lands this cycle; dividend is sum * 256
                quo_next     = {sum_add, 8'h00};
                rem_next     = '0;
                div_cnt_next = '0;
                state_next   = hms_pkg::ST_DIV;
            end

            hms_pkg::ST_DIV:
            begin
                if (div_cnt_reg == DCW'(DVW))
                begin
                    res_next.empty_window = 1'b0;
                    if ((DVW+24)'(quo_reg) > (DVW+24)'(hms_pkg::HEIGHT_MAX))
                        res_next.height = 24'(hms_pkg::HEIGHT_MAX);
                    else
                        res_next.height = 24'(quo_reg);
                    state_next = hms_pkg::ST_DONE;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                    if (rem_sh >= (CNT_W+1)'(cnt_reg))
                    begin
                        rem_next = CNT_W'(rem_sh - (CNT_W+1)'(cnt_reg));
                        quo_next = {quo_reg[DVW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = CNT_W'(rem_sh);
                        quo_next = {quo_reg[DVW-2:0], 1'b0};
                    end
                end
            end

            hms_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = hms_pkg::ST_IDLE;
                end
            end

            default: state_next = hms_pkg::ST_IDLE;
        endcase

        prod_next = 54'(mul_a) * 54'(mul_b);
    end

    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hms_pkg::ST_IDLE;
            rd_idx_reg     <= '0;
            step_reg       <= '0;
            div_cnt_reg    <= '0;
            pend_reg       <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            map_width_reg  <= hms_pkg::RST_MAP_SIDE;
            map_height_reg <= hms_pkg::RST_MAP_SIDE;
            ratio_x_reg    <= hms_pkg::RST_RATIO;
            ratio_y_reg    <= hms_pkg::RST_RATIO;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            step_reg      <= step_next;
            div_cnt_reg   <= div_cnt_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    hms_pkg::CFG_MAP_WIDTH:  map_width_reg  <= cfg_data[8:0];
                    hms_pkg::CFG_MAP_HEIGHT: map_height_reg <= cfg_data[8:0];
                    hms_pkg::CFG_RATIO_X:    ratio_x_reg    <= cfg_data;
                    hms_pkg::CFG_RATIO_Y:    ratio_y_reg    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        px_reg   <= px_next;   py_reg   <= py_next;   ext_reg <= ext_next;
        x1_reg   <= x1_next;   x2_reg   <= x2_next;
        y1_reg   <= y1_next;   y2_reg   <= y2_next;
        prod_reg <= prod_next;
        r1_reg   <= r1_next;   r2_reg   <= r2_next;   acc_reg <= acc_next;
        ppx_reg  <= ppx_next;  ppy_reg  <= ppy_next;
        sx_reg   <= sx_next;   sy_reg   <= sy_next;
        xl_reg   <= xl_next;   xh_reg   <= xh_next;
        yl_reg   <= yl_next;   yh_reg   <= yh_next;
        xc_reg   <= xc_next;   yc_reg   <= yc_next;
        cnt_reg  <= cnt_next;  sum_reg  <= sum_next;
        quo_reg  <= quo_next;  rem_reg  <= rem_next;
        res_reg  <= res_next;
        // read data of corner k arrives in the cycle after its address
        if (state_reg == hms_pkg::ST_BL_RD && rd_idx_reg != 3'd0)
            samp_reg[2'(rd_idx_reg - 3'd1)] <= rdata_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[req.map_addr] <= req.height_value;
        rdata_reg <= mem[rd_addr];
    end

`ifndef SYNTH
    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall
         && (req.func == hms_pkg::FN_BILIN || req.func == hms_pkg::FN_BOX)) |=> req_stall)
        else $error("query accepted without blocking the input");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hms_pkg::ST_DIV) |-> (cnt_reg != '0))
        else $error("divide with empty sample count");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hms_pkg::ST_BOX_SCAN) |-> ((CNT_W+1)'(cnt_reg) < (CNT_W+1)'(MAX_CNT)))
        else $error("box window exceeds its bound");

    a_done_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == hms_pkg::ST_DONE))
        else $error("result shown outside done state");
`endif

endmodule

`default_nettype wire

// File: tb/tb.sv
// Testbench for heightmap_sampler: prefilled map, directed and random queries, self-checking.
`timescale 1ns / 100ps

module tb;
    import hms_pkg::*;

    localparam int SIDE_CAP   = DEF_MAX_MAP_SIDE;
    localparam int HALF_CAP   = DEF_MAX_HALF_WINDOW;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 40;

    typedef struct {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } cfg_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    req_t                  req;
    logic                  rsp_valid;
    logic                  rsp_stall;
    rsp_t                  rsp;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    heightmap_sampler uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [7:0]  map_mirror [STORE_DEPTH];
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [15:0] ratio_x_reg;
    logic [15:0] ratio_y_reg;

    req_t      req_backlog [$];
    cfg_word_t cfg_backlog [$];
    rsp_t      height_due  [$];

    int gap_max;
    int stall_max;
    int send_gap;
    int stall_left;
    int err_count;
    int idle_cycles;
    int n_checked;
    int n_empty;
    int n_bilin;
    int n_box;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint map_at(longint x, longint y, longint w);
        logic [15:0] a;
        a = 16'(x + y * w);
        return longint'(map_mirror[a]);
    endfunction

    function automatic rsp_t bilinear_height(longint px, longint py);
        longint w, h, x1, y1, x2, y2, wa, wb, r1, r2, z;
        rsp_t r;
        w  = clamp_to(width_reg, 1, SIDE_CAP);
        h  = clamp_to(height_reg, 1, SIDE_CAP);
        x1 = px / 256;
        y1 = py / 256;
        x2 = clamp_to(x1 + 1, 0, w - 1);
        y2 = clamp_to(y1 + 1, 0, h - 1);
        x1 = clamp_to(x1, 0, w - 1);
        y1 = clamp_to(y1, 0, h - 1);
        wa = x2 * 256 - px;
        wb = px - x1 * 256;
        r1 = wa * map_at(x1, y1, w) + wb * map_at(x2, y1, w);
        r2 = wa * map_at(x1, y2, w) + wb * map_at(x2, y2, w);
        z  = (y2 * 256 - py) * r1 + (py - y1 * 256) * r2;
        r.height       = 24'(clamp_to(z >>> 8, HEIGHT_MIN, HEIGHT_MAX));
        r.empty_window = 1'b0;
        return r;
    endfunction

    // window bounds along one axis: lo = trunc(P - S), hi = ceil(P + S) - 1
    function automatic void window_span(longint pos, longint ratio, longint ext,
                                        output longint lo, output longint hi);
        longint p, s;
        p  = pos * ratio;
        s  = (ext * ratio) >> 20;
        if (s > HALF_CAP)
            s = HALF_CAP;
        s  = s << 20;
        lo = (p - s) / (longint'(1) << 20);
        hi = -((-(p + s)) >>> 20) - 1;
    endfunction

    function automatic rsp_t box_height(longint px, longint py, longint ext);
        longint w, h, xl, xh, yl, yh, sum, cnt;
        rsp_t r;
        w   = clamp_to(width_reg, 1, SIDE_CAP);
        h   = clamp_to(height_reg, 1, SIDE_CAP);
        sum = 0;
        cnt = 0;
        window_span(px, ratio_x_reg, ext, xl, xh);
        window_span(py, ratio_y_reg, ext, yl, yh);
        for (longint y = yl; y <= yh; y++)
            for (longint x = xl; x <= xh; x++)
            begin
                sum += map_at(clamp_to(x, 0, w - 1), clamp_to(y, 0, h - 1), w);
                cnt++;
            end
        r.empty_window = (cnt == 0);
        r.height       = (cnt == 0) ? 24'd0
                         : 24'(clamp_to((sum * 256) / cnt, HEIGHT_MIN, HEIGHT_MAX));
        return r;
    endfunction

    task automatic sample_height_map(req_t w);
        case (w.func)
            FN_WRITE: map_mirror[w.map_addr] = w.height_value;
            FN_BILIN:
            begin
                height_due.push_back(bilinear_height(w.pos_x, w.pos_y));
                n_bilin++;
            end
            FN_BOX:
            begin
                height_due.push_back(box_height(w.pos_x, w.pos_y, w.half_extent));
                n_box++;
            end
            default: ;
        endcase
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : drive_req
        int gap;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            send_gap  <= 0;
        end
        else if (req_valid && !req_stall)
        begin
            sample_height_map(req);
            gap = $urandom_range(0, gap_max);
            if (gap == 0 && req_backlog.size() > 0)
                req <= req_backlog.pop_front();
            else
            begin
                req_valid <= 1'b0;
                send_gap  <= gap;
            end
        end
        else if (!req_valid && req_backlog.size() > 0)
        begin
            if (send_gap > 0)
                send_gap <= send_gap - 1;
            else
            begin
                req       <= req_backlog.pop_front();
                req_valid <= 1'b1;
            end
        end
    end

    // config driver
    always @(posedge clk or negedge rst_n)
    begin : drive_cfg
        cfg_word_t c;
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAP_WIDTH:  width_reg   = cfg_data[8:0];
                    CFG_MAP_HEIGHT: height_reg  = cfg_data[8:0];
                    CFG_RATIO_X:    ratio_x_reg = cfg_data;
                    CFG_RATIO_Y:    ratio_y_reg = cfg_data;
                    default: ;
                endcase
            end
            if ((!cfg_valid || cfg_ready) && cfg_backlog.size() > 0)
            begin
                c = cfg_backlog.pop_front();
                cfg_index <= c.idx;
                cfg_data  <= c.data;
                cfg_valid <= 1'b1;
            end
            else if (cfg_valid && cfg_ready)
                cfg_valid <= 1'b0;
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin : watch_rsp
        rsp_t exp_w;
        int   n;
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (rsp_valid && !rsp_stall)
        begin
            if (height_due.size() == 0)
            begin
                $error("unexpected result word height=%0d empty=%0b",
                       rsp.height, rsp.empty_window);
                err_count++;
            end
            else
            begin
                exp_w = height_due.pop_front();
                n_checked++;
                if (exp_w.empty_window)
                    n_empty++;
                if (rsp.height !== exp_w.height)
                begin
                    $error("height: expected %0d, got %0d", exp_w.height, rsp.height);
                    err_count++;
                end
                if (rsp.empty_window !== exp_w.empty_window)
                begin
                    $error("empty_window: expected %0b, got %0b",
                           exp_w.empty_window, rsp.empty_window);
                    err_count++;
                end
            end
            n = $urandom_range(0, stall_max);
            stall_left <= n;
            rsp_stall  <= (n > 0);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_stall  <= (stall_left > 1);
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no word accepted for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic req_t make_req(logic [1:0] f, int x, int y, int ext);
        req_t r;
        r.func         = f;
        r.map_addr     = 16'($urandom);
        r.height_value = 8'($urandom);
        r.pos_x        = 20'(x);
        r.pos_y        = 20'(y);
        r.half_extent  = 19'(ext);
        return r;
    endfunction

    function automatic req_t random_req();
        int w, h, sel;
        w   = clamp_to(width_reg, 1, SIDE_CAP);
        h   = clamp_to(height_reg, 1, SIDE_CAP);
        sel = $urandom_range(0, 99);
        if (sel < 20)
            return make_req(FN_WRITE, $urandom, $urandom, $urandom);
        if (sel < 22)
            return make_req(2'd3, $urandom, $urandom, $urandom);
        if (sel < 25)
            return make_req(FN_BILIN, $urandom, $urandom, $urandom);
        if (sel < 60)
            return make_req(FN_BILIN, $urandom_range(0, w * 256 + 768) - 384,
                            $urandom_range(0, h * 256 + 768) - 384, $urandom);
        if (sel < 63)
            return make_req(FN_BOX, $urandom, $urandom, $urandom);
        return make_req(FN_BOX, $urandom_range(0, 256 * 300) - 256 * 20,
                        $urandom_range(0, 256 * 300) - 256 * 20, $urandom_range(0, 1500));
    endfunction

    task automatic wait_idle();
        wait (req_backlog.size() == 0 && !req_valid && height_due.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_map(int w, int h, int rx, int ry);
        cfg_word_t c;
        wait_idle();
        c.idx = CFG_MAP_WIDTH;  c.data = 16'(w);  cfg_backlog.push_back(c);
        c.idx = CFG_MAP_HEIGHT; c.data = 16'(h);  cfg_backlog.push_back(c);
        c.idx = CFG_RATIO_X;    c.data = 16'(rx); cfg_backlog.push_back(c);
        c.idx = CFG_RATIO_Y;    c.data = 16'(ry); cfg_backlog.push_back(c);
        wait (cfg_backlog.size() == 0 && !cfg_valid);
        @(posedge clk);
    endtask

    initial
    begin
        req_t r;
        err_count   = 0;
        idle_cycles = 0;
        n_checked   = 0;
        n_empty     = 0;
        n_bilin     = 0;
        n_box       = 0;
        width_reg   = RST_MAP_SIDE;
        height_reg  = RST_MAP_SIDE;
        ratio_x_reg = RST_RATIO;
        ratio_y_reg = RST_RATIO;
        gap_max     = 0;
        stall_max   = 0;
        rst_n       = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // fill the whole store so no query reads an unwritten sample
        for (int a = 0; a < STORE_DEPTH; a++)
        begin
            r = make_req(FN_WRITE, 0, 0, 0);
            r.map_addr = 16'(a);
            req_backlog.push_back(r);
        end
        wait_idle();

        gap_max   = 9;
        stall_max = 9;
        // directed: field extremes, ignored selector, clamped edges, empty windows
        req_backlog.push_back(make_req(FN_WRITE, 0, 0, 0));
        r = make_req(FN_WRITE, 0, 0, 0);
        r.map_addr = 16'hFFFF; r.height_value = 8'hFF;
        req_backlog.push_back(r);
        r.map_addr = 16'h0000; r.height_value = 8'h00;
        req_backlog.push_back(r);
        req_backlog.push_back(make_req(2'd3, -1, -1, 'h7FFFF));
        req_backlog.push_back(make_req(FN_BILIN, 0, 0, 0));
        req_backlog.push_back(make_req(FN_BILIN, 128, 64, 0));
        req_backlog.push_back(make_req(FN_BILIN, -524288, -524288, 0));
        req_backlog.push_back(make_req(FN_BILIN, 524287, 524287, 0));
        req_backlog.push_back(make_req(FN_BILIN, 255 * 256 + 200, 100, 0));
        req_backlog.push_back(make_req(FN_BILIN, -200, 255 * 256 + 77, 0));
        req_backlog.push_back(make_req(FN_BOX, 0, 0, 0));
        req_backlog.push_back(make_req(FN_BOX, -128, 500, 0));
        req_backlog.push_back(make_req(FN_BOX, 1000, 1000, 256));
        req_backlog.push_back(make_req(FN_BOX, 60000, 30000, 'h7FFFF));
        req_backlog.push_back(make_req(FN_BOX, -524288, 524287, 300));
        req_backlog.push_back(make_req(FN_BOX, 524287, -524288, 0));
        req_backlog.push_back(make_req(FN_BOX, 64 * 256 + 77, 32 * 256 + 3, 700));

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_map(256, 256, 4096, 4096);
                1: set_map(0, 1, 0, 65535);
                2: set_map(511, 300, 65535, 0);
                3: set_map(17, 9, 2048, 8192);
                4: set_map(1, 256, 1, 300);
                default: set_map($urandom_range(0, 511), $urandom_range(0, 511),
                                 $urandom_range(0, 16384), $urandom_range(0, 16384));
            endcase
            gap_max   = (ph == 3) ? 0 : 9;
            stall_max = (ph == 3) ? 0 : 9;
            for (int i = 0; i < 140; i++)
            begin
                if (ph == 0 && i == 70)
                    wait_idle();
                req_backlog.push_back(random_req());
            end
        end

        wait_idle();
        $display("checked %0d results: %0d bilinear, %0d box, %0d empty windows",
                 n_checked, n_bilin, n_box, n_empty);
        $display("map sizes from 1 to 511 and ratios from 0 to 65535 were exercised");
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
